@@ rtl/ppru_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppru_pkg
// Types, widths and constants shared by the packed pixel run unpacker.
// ----------------------------------------------------------------------------
package ppru_pkg;

    localparam int COORD_W = 16;
    localparam int BYTE_W  = 8;
    localparam int SKIP_W  = 12;
    localparam int CNT_W   = 13;
    localparam int BUF_W   = 16;
    localparam int HELD_W  = 4;
    localparam int BPP_W   = 4;
    localparam int COLOR_W = 8;
    localparam int STEP_W  = 2;
    localparam int TC_W    = 9;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic [BPP_W-1:0] BPP_MAX = BPP_W'(8);

    localparam logic [COLOR_W-1:0] LEAD_MASK [0:8] = '{
        8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE, 8'hFF
    };

    typedef enum logic [2:0] {
        REG_BPP         = 3'd0,
        REG_CLIP_LEFT   = 3'd1,
        REG_CLIP_RIGHT  = 3'd2,
        REG_CLIP_TOP    = 3'd3,
        REG_CLIP_BOTTOM = 3'd4,
        REG_STEP_X      = 3'd5,
        REG_STEP_Y      = 3'd6,
        REG_TRANS_COLOR = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [BPP_W-1:0]          bpp;
        logic signed [COORD_W-1:0] clip_left;
        logic signed [COORD_W-1:0] clip_right;
        logic signed [COORD_W-1:0] clip_top;
        logic signed [COORD_W-1:0] clip_bottom;
        logic [STEP_W-1:0]         step_x;
        logic [STEP_W-1:0]         step_y;
        logic                      trans_en;
        logic [COLOR_W-1:0]        trans_color;
    } t_cfg;

    typedef struct packed {
        logic                      new_run;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic [SKIP_W-1:0]         skip;
        logic [CNT_W-1:0]          count;
        logic [BYTE_W-1:0]         data;
    } t_cmd;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COLOR_W-1:0]        color;
        logic                      run_done;
    } t_pix;

    // Right-aligned mask of bpp ones, taken from the leading-bit table.
    function automatic logic [COLOR_W-1:0] pixel_mask(input logic [BPP_W-1:0] bpp);
        return LEAD_MASK[bpp] >> (BPP_MAX - bpp);
    endfunction

endpackage
`default_nettype wire

@@ rtl/ppru_byte_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppru_byte_if
// Input channel: one packed bitmap byte per item, with run start fields.
// ----------------------------------------------------------------------------
interface ppru_byte_if import ppru_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      run_start;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic [SKIP_W-1:0]         skip_pixels;
    logic [CNT_W-1:0]          pixel_count;
    logic [BYTE_W-1:0]         data_byte;

    modport source (
        output valid, run_start, start_x, start_y, skip_pixels, pixel_count, data_byte,
        input  ready
    );
    modport sink (
        input  valid, run_start, start_x, start_y, skip_pixels, pixel_count, data_byte,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/ppru_pix_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppru_pix_if
// Output channel: one pixel write per item.
// ----------------------------------------------------------------------------
interface ppru_pix_if import ppru_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      run_done;
    logic                      last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, run_done, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, run_done, last,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/ppru_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppru_regs
// APB configuration registers; presents the decoded settings as one struct.
// ----------------------------------------------------------------------------
module ppru_regs import ppru_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    logic [BPP_W-1:0]   r_bpp;
    logic [COORD_W-1:0] r_clip_left;
    logic [COORD_W-1:0] r_clip_right;
    logic [COORD_W-1:0] r_clip_top;
    logic [COORD_W-1:0] r_clip_bottom;
    logic [STEP_W-1:0]  r_step_x;
    logic [STEP_W-1:0]  r_step_y;
    logic [TC_W-1:0]    r_trans;
    logic               wr_en;
    t_reg_idx           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp         <= BPP_W'(1);
            r_clip_left   <= '0;
            r_clip_right  <= COORD_W'(127);
            r_clip_top    <= '0;
            r_clip_bottom <= COORD_W'(63);
            r_step_x      <= STEP_W'(1);
            r_step_y      <= '0;
            r_trans       <= '1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BPP:         r_bpp         <= pwdata[BPP_W-1:0];
                REG_CLIP_LEFT:   r_clip_left   <= pwdata[COORD_W-1:0];
                REG_CLIP_RIGHT:  r_clip_right  <= pwdata[COORD_W-1:0];
                REG_CLIP_TOP:    r_clip_top    <= pwdata[COORD_W-1:0];
                REG_CLIP_BOTTOM: r_clip_bottom <= pwdata[COORD_W-1:0];
                REG_STEP_X:      r_step_x      <= pwdata[STEP_W-1:0];
                REG_STEP_Y:      r_step_y      <= pwdata[STEP_W-1:0];
                REG_TRANS_COLOR: r_trans       <= pwdata[TC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BPP:         prdata = DATA_W'(r_bpp);
            REG_CLIP_LEFT:   prdata = DATA_W'(r_clip_left);
            REG_CLIP_RIGHT:  prdata = DATA_W'(r_clip_right);
            REG_CLIP_TOP:    prdata = DATA_W'(r_clip_top);
            REG_CLIP_BOTTOM: prdata = DATA_W'(r_clip_bottom);
            REG_STEP_X:      prdata = DATA_W'(r_step_x);
            REG_STEP_Y:      prdata = DATA_W'(r_step_y);
            REG_TRANS_COLOR: prdata = DATA_W'(r_trans);
            default:         prdata = '0;
        endcase
    end

    // A width of zero behaves as one bit and anything above eight as eight.
    always_comb begin
        if (r_bpp == '0) begin
            o_cfg.bpp = BPP_W'(1);
        end else if (r_bpp > BPP_MAX) begin
            o_cfg.bpp = BPP_MAX;
        end else begin
            o_cfg.bpp = r_bpp;
        end
        o_cfg.clip_left   = r_clip_left;
        o_cfg.clip_right  = r_clip_right;
        o_cfg.clip_top    = r_clip_top;
        o_cfg.clip_bottom = r_clip_bottom;
        o_cfg.step_x      = r_step_x;
        o_cfg.step_y      = r_step_y;
        // Any negative transparent color turns transparency off.
        o_cfg.trans_en    = !r_trans[TC_W-1];
        o_cfg.trans_color = r_trans[COLOR_W-1:0];
    end

endmodule
`default_nettype wire

@@ rtl/ppru_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppru_front
// Input stage: registers each byte item and turns it into a command, with the
// run length saturated to the largest supported run.
// ----------------------------------------------------------------------------
module ppru_front import ppru_pkg::*; #(
    parameter int MAX_RUN = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ppru_byte_if.sink i_byte,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_ready
);

    localparam int CNT_MAX = (MAX_RUN < (2**CNT_W - 1)) ? MAX_RUN : (2**CNT_W - 1);

    logic             r_valid;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic             take;
    logic [CNT_W-1:0] cnt_sat;

    assign i_byte.ready = !r_valid || i_cmd_ready;
    assign take         = i_byte.valid && i_byte.ready;
    assign o_cmd_valid  = r_valid;
    assign o_cmd        = r_cmd;

    always_comb begin
        if (32'(i_byte.pixel_count) > 32'(CNT_MAX)) begin
            cnt_sat = CNT_W'(CNT_MAX);
        end else begin
            cnt_sat = i_byte.pixel_count;
        end
        n_cmd.new_run = i_byte.run_start;
        n_cmd.start_x = i_byte.start_x;
        n_cmd.start_y = i_byte.start_y;
        n_cmd.skip    = i_byte.skip_pixels;
        n_cmd.count   = cnt_sat;
        n_cmd.data    = i_byte.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ppru_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppru_queue
// Short command queue between the input stage and the pixel engine.
// ----------------------------------------------------------------------------
module ppru_queue import ppru_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_cmd i_push,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_cmd      o_pop
);

    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != CW'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop        = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ppru_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ppru_back
// Pixel engine: takes one pixel per cycle from the bit buffer unless stalled,
// clips it, holds each visible write back by one, and marks a byte's last write.
// ----------------------------------------------------------------------------
module ppru_back import ppru_pkg::*; #(
    parameter int MAX_RUN = 4096
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_cmd_valid,
    input  wire t_cmd   i_cmd,
    output logic        o_cmd_ready,
    ppru_pix_if.source  o_pix
);

    localparam int CNT_MAX = (MAX_RUN < (2**CNT_W - 1)) ? MAX_RUN : (2**CNT_W - 1);
    localparam int PL_W    = $clog2(CNT_MAX + 1);

    // Engine state.
    logic                      r_work,  n_work;
    logic [BUF_W-1:0]          r_buf,   n_buf;
    logic [HELD_W-1:0]         r_held,  n_held;
    logic signed [COORD_W-1:0] r_x,     n_x;
    logic signed [COORD_W-1:0] r_y,     n_y;
    logic [SKIP_W-1:0]         r_skip,  n_skip;
    logic [PL_W-1:0]           r_pl,    n_pl;

    // Held write and output register.
    logic r_h_valid, n_h_valid;
    logic r_h_last,  n_h_last;
    t_pix r_h,       n_h;
    logic r_out_valid;
    logic r_out_last;
    t_pix r_out;

    logic               out_free;
    logic               step_en;
    logic               pop;
    logic               hold_go;
    logic               out_last;
    logic [HELD_W-1:0]  held1;
    logic [COLOR_W-1:0] color;
    logic               is_skip;
    logic               in_clip;
    logic               vis;
    logic               eob;
    t_pix               ev;

    assign out_free = !r_out_valid || o_pix.ready;
    assign step_en  = r_work && (!r_h_valid || out_free);

    always_comb begin
        held1   = r_held - i_cfg.bpp;
        color   = COLOR_W'(r_buf >> held1) & pixel_mask(i_cfg.bpp);
        is_skip = (r_skip != '0);
        in_clip = (r_x >= i_cfg.clip_left) && (r_x <= i_cfg.clip_right) &&
                  (r_y >= i_cfg.clip_top)  && (r_y <= i_cfg.clip_bottom);
        vis     = !is_skip && in_clip && (!i_cfg.trans_en || color != i_cfg.trans_color);

        n_work = r_work;
        n_buf  = r_buf;
        n_held = r_held;
        n_x    = r_x;
        n_y    = r_y;
        n_skip = r_skip;
        n_pl   = r_pl;

        ev.x        = r_x;
        ev.y        = r_y;
        ev.color    = color;
        ev.run_done = (r_pl == PL_W'(1));

        // Extract one pixel: skipped pixels use bits but do not move.
        if (step_en) begin
            n_held = held1;
            n_buf  = r_buf & ((BUF_W'(1) << held1) - BUF_W'(1));
            if (is_skip) begin
                n_skip = r_skip - SKIP_W'(1);
            end else begin
                n_pl = r_pl - PL_W'(1);
                n_x  = r_x + {{(COORD_W-STEP_W){i_cfg.step_x[STEP_W-1]}}, i_cfg.step_x};
                n_y  = r_y + {{(COORD_W-STEP_W){i_cfg.step_y[STEP_W-1]}}, i_cfg.step_y};
            end
        end

        eob = !((held1 >= i_cfg.bpp) && (n_pl != '0));

        if (step_en && eob) begin
            n_work = 1'b0;
            if (n_pl == '0) begin
                n_buf  = '0;
                n_held = '0;
                n_skip = '0;
            end
        end

        // The next byte is loaded in the cycle that finishes the current one.
        pop = i_cmd_valid && (!r_work || (step_en && eob));
        if (pop) begin
            if (i_cmd.new_run) begin
                n_x    = i_cmd.start_x;
                n_y    = i_cmd.start_y;
                n_skip = i_cmd.skip;
                n_pl   = PL_W'(i_cmd.count);
                n_buf  = '0;
                n_held = '0;
            end
            // Without an active run the byte is dropped.
            if (n_pl != '0) begin
                n_buf  = {n_buf[BUF_W-BYTE_W-1:0], i_cmd.data};
                n_held = n_held + HELD_W'(BYTE_W);
                n_work = 1'b1;
            end
        end
    end

    assign o_cmd_ready = !r_work || (step_en && eob);

    // A held write leaves once it is known whether a later write of the same
    // byte follows; a visible pixel with nothing after it is flagged last.
    always_comb begin
        hold_go   = r_h_valid && out_free &&
                    (r_h_last || (step_en && (vis || eob)));
        out_last  = r_h_last || (step_en && eob && !vis);
        n_h_valid = r_h_valid;
        n_h_last  = r_h_last;
        n_h       = r_h;
        if (step_en && vis) begin
            n_h_valid = 1'b1;
            n_h_last  = eob;
            n_h       = ev;
        end else if (hold_go) begin
            n_h_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work      <= 1'b0;
            r_buf       <= '0;
            r_held      <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_skip      <= '0;
            r_pl        <= '0;
            r_h_valid   <= 1'b0;
            r_h_last    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_work    <= n_work;
            r_buf     <= n_buf;
            r_held    <= n_held;
            r_x       <= n_x;
            r_y       <= n_y;
            r_skip    <= n_skip;
            r_pl      <= n_pl;
            r_h_valid <= n_h_valid;
            r_h_last  <= n_h_last;
            if (hold_go) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h <= n_h;
        if (hold_go) begin
            r_out      <= r_h;
            r_out_last <= out_last;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_x     = r_out.x;
    assign o_pix.pixel_y     = r_out.y;
    assign o_pix.pixel_color = r_out.color;
    assign o_pix.run_done    = r_out.run_done;
    assign o_pix.last        = r_out_last;

endmodule
`default_nettype wire

@@ rtl/packed_pixel_run_unpack.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// packed_pixel_run_unpack
// Unpacks runs of 1..8 bit packed pixels into clipped pixel writes.
// ----------------------------------------------------------------------------
// Usage: i_byte carries one bitmap byte per item (valid/ready); the first
// item of a run also carries start position, skip count and pixel count.
// o_pix carries one pixel write per item, with run_done on the final pixel
// of a run and last on the final write caused by an input byte. The APB port
// (psel/penable/pwrite, registers at byte address 4*index) sets pixel width,
// clip rectangle, step and transparent color; write it only while idle.
// Throughput: the pixel engine takes one pixel per cycle unless a write waits
// on a stalled o_pix; the next byte is loaded in the cycle that finishes the
// current one. Path: an accepted byte passes the input register and the
// command queue to the engine; a visible pixel is held until the next visible
// pixel or the end of its byte, then goes through the output register to o_pix.
// Reset: synchronous, clears all control state and loads the register
// defaults; no run is active afterwards. When o_pix stalls, the engine stops
// while a write waits, and a two-entry queue plus the input register keep
// accepting bytes until they fill.
// ----------------------------------------------------------------------------
module packed_pixel_run_unpack import ppru_pkg::*; #(
    parameter int MAX_RUN = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ppru_byte_if.sink              i_byte,
    ppru_pix_if.source             o_pix,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg cfg;
    logic fq_valid;
    logic fq_ready;
    t_cmd fq_cmd;
    logic qb_valid;
    logic qb_ready;
    t_cmd qb_cmd;

    ppru_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ppru_front #(.MAX_RUN(MAX_RUN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .o_cmd_valid (fq_valid),
        .o_cmd       (fq_cmd),
        .i_cmd_ready (fq_ready)
    );

    ppru_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push       (fq_cmd),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop        (qb_cmd)
    );

    ppru_back #(.MAX_RUN(MAX_RUN)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (qb_valid),
        .i_cmd       (qb_cmd),
        .o_cmd_ready (qb_ready),
        .o_pix       (o_pix)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb_packed_pixel_run_unpack.sv @@
// ----------------------------------------------------------------------------
// tb_packed_pixel_run_unpack
// Self-checking bench for the packed pixel run unpacker. Bitmap bytes are
// driven on the byte channel while pixel writes are collected on the pixel
// channel. A short table of directed bytes walks the corner cases, then
// random register settings and random runs follow. Each write is compared with
// an in-bench unpacker (bit buffer, position, run count) or a typed expectation.
// ----------------------------------------------------------------------------
module tb_packed_pixel_run_unpack;
    import ppru_pkg::*;

    localparam int RUN_CAP         = 4096;
    localparam int TOTAL_ITEMS     = 410;
    localparam int DRAIN_CYCLES    = 60;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int REPORT_MAX      = 10;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COLOR_W-1:0]        color;
        logic                      run_done;
        logic                      last;
    } t_pix_write;

    typedef enum logic {ROW_BYTE, ROW_REG} t_row_kind;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} t_check;

    typedef struct {
        t_row_kind   kind;
        t_reg_idx    reg_idx;
        logic [31:0] reg_val;
        t_cmd        cmd;
        t_check      chk;
        t_pix_write  typed;
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ppru_byte_if byte_ch();
    ppru_pix_if  pix_ch();

    packed_pixel_run_unpack u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_pix   (pix_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Register copies seen by the unpacker below.
    logic [BPP_W-1:0]          cfg_bpp;
    logic signed [COORD_W-1:0] cfg_clip_left;
    logic signed [COORD_W-1:0] cfg_clip_right;
    logic signed [COORD_W-1:0] cfg_clip_top;
    logic signed [COORD_W-1:0] cfg_clip_bottom;
    logic signed [STEP_W-1:0]  cfg_step_x;
    logic signed [STEP_W-1:0]  cfg_step_y;
    logic signed [TC_W-1:0]    cfg_trans;

    // Unpacker state.
    logic [BUF_W-1:0]          bit_acc;
    int                        bits_held;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    int                        pixels_left;
    int                        skip_left;

    t_pix_write pending_writes[$];
    t_pix_write byte_writes[$];
    t_dir_row   directed_rows[$];

    int mismatches     = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int src_gap_max    = 9;
    int sink_stall_max = 9;
    bit hold_off_req   = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("MISMATCH: %s", msg);
    endfunction

    function automatic void reset_unpacker();
        cfg_bpp         = 4'd1;
        cfg_clip_left   = 16'sd0;
        cfg_clip_right  = 16'sd127;
        cfg_clip_top    = 16'sd0;
        cfg_clip_bottom = 16'sd63;
        cfg_step_x      = 2'sd1;
        cfg_step_y      = 2'sd0;
        cfg_trans       = -9'sd1;
        bit_acc         = '0;
        bits_held       = 0;
        pos_x           = '0;
        pos_y           = '0;
        pixels_left     = 0;
        skip_left       = 0;
    endfunction

    // Unpacks one byte into byte_writes.
    function automatic void unpack_byte(input t_cmd cmd);
        int               w;
        logic [COLOR_W-1:0] color;
        t_pix_write       wr;
        byte_writes.delete();
        w = (cfg_bpp == 0) ? 1 : (cfg_bpp > BPP_MAX) ? 8 : int'(cfg_bpp);
        if (cmd.new_run) begin
            pixels_left = (cmd.count > CNT_W'(RUN_CAP)) ? RUN_CAP : int'(cmd.count);
            pos_x       = cmd.start_x;
            pos_y       = cmd.start_y;
            skip_left   = int'(cmd.skip);
            bit_acc     = '0;
            bits_held   = 0;
        end
        if (pixels_left == 0) return;
        bit_acc   = {bit_acc[7:0], cmd.data};
        bits_held = bits_held + 8;
        while (bits_held >= w && pixels_left > 0) begin
            color     = COLOR_W'((bit_acc >> (bits_held - w)) & ((16'd1 << w) - 16'd1));
            bits_held = bits_held - w;
            bit_acc   = bit_acc & ((16'd1 << bits_held) - 16'd1);
            if (skip_left > 0) begin
                skip_left--;
            end else begin
                pixels_left--;
                if (pos_x >= cfg_clip_left && pos_x <= cfg_clip_right &&
                    pos_y >= cfg_clip_top && pos_y <= cfg_clip_bottom &&
                    $signed({1'b0, color}) != cfg_trans) begin
                    wr.x        = pos_x;
                    wr.y        = pos_y;
                    wr.color    = color;
                    wr.run_done = (pixels_left == 0);
                    wr.last     = 1'b0;
                    byte_writes.push_back(wr);
                end
                pos_x = pos_x + {{(COORD_W-STEP_W){cfg_step_x[1]}}, cfg_step_x};
                pos_y = pos_y + {{(COORD_W-STEP_W){cfg_step_y[1]}}, cfg_step_y};
            end
        end
        // Leftover bits of a finished run are dropped.
        if (pixels_left == 0) begin
            bit_acc   = '0;
            bits_held = 0;
            skip_left = 0;
        end
        if (byte_writes.size() > 0) byte_writes[byte_writes.size()-1].last = 1'b1;
    endfunction

    function automatic void add_reg(input t_reg_idx idx, input logic [31:0] val);
        t_dir_row row;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        row.cmd     = '0;
        row.chk     = CHK_NONE;
        row.typed   = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_byte(input bit rs, input int sx, input int sy,
                                     input int skip, input int cnt, input int data,
                                     input t_check chk, input int ex, input int ey,
                                     input int ecolor, input bit edone);
        t_dir_row row;
        row.kind           = ROW_BYTE;
        row.reg_idx        = REG_BPP;
        row.reg_val        = '0;
        row.cmd.new_run    = rs;
        row.cmd.start_x    = COORD_W'(sx);
        row.cmd.start_y    = COORD_W'(sy);
        row.cmd.skip       = SKIP_W'(skip);
        row.cmd.count      = CNT_W'(cnt);
        row.cmd.data       = BYTE_W'(data);
        row.chk            = chk;
        row.typed.x        = COORD_W'(ex);
        row.typed.y        = COORD_W'(ey);
        row.typed.color    = COLOR_W'(ecolor);
        row.typed.run_done = edone;
        row.typed.last     = 1'b1;
        directed_rows.push_back(row);
    endfunction

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BPP:         cfg_bpp         = val[BPP_W-1:0];
            REG_CLIP_LEFT:   cfg_clip_left   = val[COORD_W-1:0];
            REG_CLIP_RIGHT:  cfg_clip_right  = val[COORD_W-1:0];
            REG_CLIP_TOP:    cfg_clip_top    = val[COORD_W-1:0];
            REG_CLIP_BOTTOM: cfg_clip_bottom = val[COORD_W-1:0];
            REG_STEP_X:      cfg_step_x      = val[STEP_W-1:0];
            REG_STEP_Y:      cfg_step_y      = val[STEP_W-1:0];
            REG_TRANS_COLOR: cfg_trans       = val[TC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_byte(input t_cmd cmd, input t_check chk, input t_pix_write typed);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.run_start   <= cmd.new_run;
        byte_ch.start_x     <= cmd.start_x;
        byte_ch.start_y     <= cmd.start_y;
        byte_ch.skip_pixels <= cmd.skip;
        byte_ch.pixel_count <= cmd.count;
        byte_ch.data_byte   <= cmd.data;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        unpack_byte(cmd);
        items_sent++;
        case (chk)
            CHK_MODEL: foreach (byte_writes[i]) pending_writes.push_back(byte_writes[i]);
            CHK_ONE:   pending_writes.push_back(typed);
            default: ;
        endcase
    endtask

    // Registers may only change once the block has nothing left in flight.
    task automatic wait_idle();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input int phase);
        int                        w;
        int                        r;
        int                        clip_w;
        int                        clip_h;
        int                        n_runs;
        int                        n_bytes;
        int                        need;
        int                        eff_cnt;
        logic [BPP_W-1:0]          bpp;
        logic signed [COORD_W-1:0] cl;
        logic signed [COORD_W-1:0] ct;
        logic [TC_W-1:0]           tc;
        t_cmd                      cmd;
        t_pix_write                no_write;
        no_write = '0;
        wait_idle();

        if (phase == 0) bpp = 4'd1;
        else if (phase == 1) bpp = 4'd8;
        else begin
            r   = $urandom_range(0, 9);
            bpp = (r < 8) ? BPP_W'(r + 1) : BPP_W'($urandom_range(0, 15));
        end
        w = (bpp == 0) ? 1 : (bpp > BPP_MAX) ? 8 : int'(bpp);

        // The pressure phase keeps every pixel visible so that writes back up.
        if (phase == 2 || $urandom_range(0, 3) == 0) begin
            cl     = -16'sd32768;
            ct     = -16'sd32768;
            clip_w = 65535;
            clip_h = 65535;
        end else begin
            cl     = COORD_W'($urandom);
            ct     = COORD_W'($urandom);
            clip_w = $urandom_range(0, 150);
            clip_h = $urandom_range(0, 60);
        end

        r = $urandom_range(0, 5);
        if (r == 0 || phase == 2) tc = 9'h1FF;
        else if (r == 1) tc = {1'b1, 8'($urandom)};
        else tc = TC_W'($urandom_range(0, (1 << w) - 1));

        apb_write(REG_BPP, 32'(bpp));
        apb_write(REG_CLIP_LEFT, 32'(cl));
        apb_write(REG_CLIP_RIGHT, 32'(16'(cl + clip_w)));
        apb_write(REG_CLIP_TOP, 32'(ct));
        apb_write(REG_CLIP_BOTTOM, 32'(16'(ct + clip_h)));
        apb_write(REG_STEP_X, 32'(2'($urandom_range(0, 2) - 1)));
        apb_write(REG_STEP_Y, 32'(2'($urandom_range(0, 2) - 1)));
        apb_write(REG_TRANS_COLOR, 32'(tc));

        src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 9;
        sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
        // Long receiver stall against a sender that never pauses.
        if (phase == 2) begin
            hold_off_req = 1'b1;
            src_gap_max  = 0;
        end

        n_runs = (phase == 2) ? 8 : $urandom_range(3, 8);
        for (int run = 0; run < n_runs && items_sent < TOTAL_ITEMS; run++) begin
            cmd.new_run = 1'b1;
            if ($urandom_range(0, 7) == 0) begin
                cmd.start_x = COORD_W'($urandom);
                cmd.start_y = COORD_W'($urandom);
            end else begin
                cmd.start_x = COORD_W'(cl + $urandom_range(0, clip_w + 8) - 4);
                cmd.start_y = COORD_W'(ct + $urandom_range(0, clip_h + 8) - 4);
            end
            cmd.skip  = ($urandom_range(0, 9) == 0) ? SKIP_W'($urandom_range(0, 4095))
                                                     : SKIP_W'($urandom_range(0, 6));
            r = $urandom_range(0, 19);
            if (r == 0) cmd.count = '0;
            else if (r < 3) cmd.count = CNT_W'($urandom_range(0, 8191));
            else cmd.count = CNT_W'($urandom_range(1, 40));
            cmd.data = BYTE_W'($urandom);

            eff_cnt = (cmd.count > CNT_W'(RUN_CAP)) ? RUN_CAP : int'(cmd.count);
            need    = ((int'(cmd.skip) + eff_cnt) * w + 7) / 8;
            if (eff_cnt == 0) need = 1;
            if (need > 12) need = 12;
            n_bytes = need;
            r = $urandom_range(0, 9);
            if (r == 0) n_bytes = $urandom_range(1, need);
            else if (r == 1) n_bytes = need + $urandom_range(1, 2);

            for (int b = 0; b < n_bytes && items_sent < TOTAL_ITEMS; b++) begin
                if (b > 0) begin
                    // Run fields of a follow-on byte carry noise and must not matter.
                    cmd.new_run = 1'b0;
                    cmd.start_x = COORD_W'($urandom);
                    cmd.start_y = COORD_W'($urandom);
                    cmd.skip    = SKIP_W'($urandom);
                    cmd.count   = CNT_W'($urandom);
                    cmd.data    = BYTE_W'($urandom);
                end
                send_byte(cmd, CHK_MODEL, no_write);
            end
        end
    endtask

    // Pixel receiver with random stalls, checking every accepted write.
    initial begin : pixel_sink
        int         stall;
        t_pix_write got;
        t_pix_write want;
        pix_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall        = hold_off_req ? HOLD_OFF_CYCLES : $urandom_range(0, sink_stall_max);
            hold_off_req = 1'b0;
            if (stall > 0) begin
                @(negedge i_clk);
                pix_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            pix_ch.ready <= 1'b1;
            do @(posedge i_clk); while (pix_ch.valid !== 1'b1);
            got.x        = pix_ch.pixel_x;
            got.y        = pix_ch.pixel_y;
            got.color    = pix_ch.pixel_color;
            got.run_done = pix_ch.run_done;
            got.last     = pix_ch.last;
            if (pending_writes.size() == 0) begin
                note_mismatch($sformatf("unexpected write x=%0d y=%0d color=%0h",
                                        got.x, got.y, got.color));
            end else begin
                want = pending_writes.pop_front();
                if (got !== want)
                    note_mismatch($sformatf({"exp x=%0d y=%0d color=%0h done=%0b last=%0b",
                                             " got x=%0d y=%0d color=%0h done=%0b last=%0b"},
                                            want.x, want.y, want.color, want.run_done,
                                            want.last, got.x, got.y, got.color,
                                            got.run_done, got.last));
            end
        end
    end

    initial begin : stimulus
        int phase;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        byte_ch.valid       = 1'b0;
        byte_ch.run_start   = 1'b0;
        byte_ch.start_x     = '0;
        byte_ch.start_y     = '0;
        byte_ch.skip_pixels = '0;
        byte_ch.pixel_count = '0;
        byte_ch.data_byte   = '0;
        reset_unpacker();

        // Defaults after reset: 1-bit pixels, clip 0..127 x 0..63, step +1 in x.
        add_byte(0, 0, 0, 0, 0, 8'hFF, CHK_NONE, 0, 0, 0, 0);
        add_byte(1, 0, 0, 0, 0, 8'hFF, CHK_NONE, 0, 0, 0, 0);
        add_byte(1, 5, 7, 0, 1, 8'h80, CHK_ONE, 5, 7, 1, 1);
        add_byte(1, 0, 0, 0, 8, 8'hA5, CHK_MODEL, 0, 0, 0, 0);
        add_byte(0, 0, 0, 0, 0, 8'hFF, CHK_NONE, 0, 0, 0, 0);
        add_byte(1, -1, 0, 0, 2, 8'hC0, CHK_ONE, 0, 0, 1, 1);
        add_byte(1, 127, 63, 4095, 4096, 8'h00, CHK_NONE, 0, 0, 0, 0);
        add_byte(1, 32767, 32767, 0, 8191, 8'hFF, CHK_NONE, 0, 0, 0, 0);
        add_byte(0, 0, 0, 0, 0, 8'h55, CHK_MODEL, 0, 0, 0, 0);
        add_byte(1, -32768, -32768, 0, 3, 8'hE0, CHK_NONE, 0, 0, 0, 0);
        // A new run must drop the two bits held over from the previous one.
        add_reg(REG_BPP, 32'd3);
        add_byte(1, 0, 0, 0, 5, 8'hFF, CHK_MODEL, 0, 0, 0, 0);
        add_byte(1, 10, 0, 0, 1, 8'h20, CHK_ONE, 10, 0, 1, 1);
        // Final pixel transparent, so no write carries run_done.
        add_reg(REG_TRANS_COLOR, 32'd0);
        add_byte(1, 1, 1, 0, 2, 8'hE0, CHK_ONE, 1, 1, 7, 0);
        add_reg(REG_TRANS_COLOR, 32'h100);
        add_byte(1, 2, 2, 0, 2, 8'h00, CHK_MODEL, 0, 0, 0, 0);
        add_reg(REG_BPP, 32'd0);
        add_byte(1, 0, 3, 0, 1, 8'h80, CHK_ONE, 0, 3, 1, 1);
        add_reg(REG_BPP, 32'd15);
        add_byte(1, 4, 4, 0, 1, 8'hAB, CHK_ONE, 4, 4, 8'hAB, 1);
        add_reg(REG_BPP, 32'd9);
        add_byte(1, 6, 5, 1, 1, 8'h11, CHK_NONE, 0, 0, 0, 0);
        add_byte(0, 0, 0, 0, 0, 8'h22, CHK_ONE, 6, 5, 8'h22, 1);
        // Full-range clip with step -1 in x: x wraps from the bottom to the top.
        add_reg(REG_CLIP_LEFT, 32'h8000);
        add_reg(REG_CLIP_RIGHT, 32'h7FFF);
        add_reg(REG_STEP_X, 32'h3);
        add_byte(1, -32768, 0, 0, 2, 8'h12, CHK_ONE, -32768, 0, 8'h12, 0);
        add_byte(0, 0, 0, 0, 0, 8'h34, CHK_ONE, 32767, 0, 8'h34, 1);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                wait_idle();
                apb_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                send_byte(directed_rows[i].cmd, directed_rows[i].chk, directed_rows[i].typed);
            end
        end

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            run_random_phase(phase);
            phase++;
        end
        wait_idle();

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ppru_pkg.sv
rtl/ppru_byte_if.sv
rtl/ppru_pix_if.sv
rtl/ppru_regs.sv
rtl/ppru_front.sv
rtl/ppru_queue.sv
rtl/ppru_back.sv
rtl/packed_pixel_run_unpack.sv
tb/sv/tb_packed_pixel_run_unpack.sv
